// ----- sv/pps_pkg.sv -----
`timescale 1ns / 1ps

package pps_pkg;

    // Angles are carried internally in Q.30 radians.
    localparam int ZW = 36;
    typedef logic signed [ZW-1:0] t_angle;

    localparam t_angle PI_Q30      = 36'sd3373259426;
    localparam t_angle HALF_PI_Q30 = 36'sd1686629713;
    localparam t_angle TWO_PI_Q30  = 36'sd6746518852;
    localparam t_angle UNIT_Q30    = 36'sd1073741824;

    localparam int MAX_STAGES = 24;

    // atan(2^-i) in Q.30.
    localparam t_angle ATAN_TAB [0:MAX_STAGES-1] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
        36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
        36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
        36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
        36'sd1024,      36'sd512,       36'sd256,       36'sd128
    };

    localparam logic [15:0] STEER_GAIN_RST = 16'd8602;

endpackage

// ----- sv/pps_vector.sv -----
`timescale 1ns / 1ps

module pps_vector
    import pps_pkg::*;
#(
    parameter int W      = 36,
    parameter int STAGES = 16,
    parameter int SB_W   = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  t_angle              i_z,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output t_angle              o_z,
    output logic [SB_W-1:0]     o_sb
);

    logic                r_vld [0:STAGES-1];
    logic signed [W-1:0] r_x   [0:STAGES-1];
    logic signed [W-1:0] r_y   [0:STAGES-2];
    t_angle              r_z   [0:STAGES-1];
    logic [SB_W-1:0]     r_sb  [0:STAGES-1];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            logic                vld_in;
            logic signed [W-1:0] x_in, y_in, ys;
            t_angle              z_in;
            logic [SB_W-1:0]     sb_in;

            if (g == 0) begin : g_first
                assign vld_in = i_valid;
                assign x_in   = i_x;
                assign y_in   = i_y;
                assign z_in   = i_z;
                assign sb_in  = i_sb;
            end else begin : g_next
                assign vld_in = r_vld[g-1];
                assign x_in   = r_x[g-1];
                assign y_in   = r_y[g-1];
                assign z_in   = r_z[g-1];
                assign sb_in  = r_sb[g-1];
            end

            assign ys = y_in >>> g;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            // Rotate toward the positive x axis.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g]  <= y_in[W-1] ? x_in - ys : x_in + ys;
                    r_z[g]  <= y_in[W-1] ? z_in - ATAN_TAB[g] : z_in + ATAN_TAB[g];
                    r_sb[g] <= sb_in;
                end
            end

            if (g < STAGES - 1) begin : g_y
                logic signed [W-1:0] xs;

                assign xs = x_in >>> g;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_y[g] <= y_in[W-1] ? y_in + xs : y_in - xs;
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_z     = r_z[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

// ----- sv/pps_rotate.sv -----
`timescale 1ns / 1ps

module pps_rotate
    import pps_pkg::*;
#(
    parameter int W      = 34,
    parameter int STAGES = 16,
    parameter int SB_W   = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_angle              i_z,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic signed [W-1:0] o_y,
    output logic [SB_W-1:0]     o_sb
);

    logic                r_vld [0:STAGES-1];
    logic signed [W-1:0] r_x   [0:STAGES-2];
    logic signed [W-1:0] r_y   [0:STAGES-1];
    t_angle              r_z   [0:STAGES-2];
    logic [SB_W-1:0]     r_sb  [0:STAGES-1];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            logic                vld_in;
            logic signed [W-1:0] x_in, y_in, xs;
            t_angle              z_in;
            logic [SB_W-1:0]     sb_in;

            if (g == 0) begin : g_first
                // The vector starts at (1, 0).
                assign vld_in = i_valid;
                assign x_in   = W'(UNIT_Q30);
                assign y_in   = '0;
                assign z_in   = i_z;
                assign sb_in  = i_sb;
            end else begin : g_next
                assign vld_in = r_vld[g-1];
                assign x_in   = r_x[g-1];
                assign y_in   = r_y[g-1];
                assign z_in   = r_z[g-1];
                assign sb_in  = r_sb[g-1];
            end

            assign xs = x_in >>> g;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[g]  <= z_in[ZW-1] ? y_in - xs : y_in + xs;
                    r_sb[g] <= sb_in;
                end
            end

            if (g < STAGES - 1) begin : g_xz
                logic signed [W-1:0] ys;

                assign ys = y_in >>> g;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[g] <= z_in[ZW-1] ? x_in + ys : x_in - ys;
                        r_z[g] <= z_in[ZW-1] ? z_in + ATAN_TAB[g] : z_in - ATAN_TAB[g];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[STAGES-1];
    assign o_y     = r_y[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

// ----- sv/pure_pursuit_steering.sv -----
`timescale 1ns / 1ps
// Throughput: one request per cycle while o_ready is high; three unrolled CORDIC
// pipelines set the depth.
// Reset is synchronous and active low: it empties the pipeline and the output
// buffer and sets steer_gain to 8602 (2.1 in Q4.12).

module pure_pursuit_steering
    import pps_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_steer_rate,
    output logic signed [15:0] o_bearing_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_steer_gain
);

    localparam int SH  = 30 - ANGLE_FRAC_BITS;
    localparam int V1W = 36;
    localparam int RW  = 34;
    localparam int V2W = 48;

    function automatic t_angle wrap_once(input t_angle a);
        if (a < -PI_Q30) begin
            return a + TWO_PI_Q30;
        end
        if (a > PI_Q30) begin
            return a - TWO_PI_Q30;
        end
        return a;
    endfunction

    // Round half up to the output grid, then saturate.
    function automatic logic signed [15:0] to_out(input t_angle a);
        t_angle r;
        r = (a + (t_angle'(1) <<< (SH - 1))) >>> SH;
        if (r > t_angle'(32767)) begin
            return 16'sh7fff;
        end
        if (r < -t_angle'(32768)) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    logic en;
    logic arrive;

    logic [15:0] r_steer_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_gain <= STEER_GAIN_RST;
        end else if (i_cfg_valid) begin
            r_steer_gain <= i_cfg_steer_gain;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Stage A: offset to the goal.
    logic               r_a_vld;
    logic signed [32:0] r_a_dx, r_a_dy;
    logic signed [15:0] r_a_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= 33'(i_goal_x) - 33'(i_robot_x);
            r_a_dy <= 33'(i_goal_y) - 33'(i_robot_y);
            r_a_hd <= i_robot_heading;
        end
    end

    // Stage B: fold the left half plane onto the right one.
    logic signed [V1W-1:0] b_dx, b_dy;
    logic                  r_b_vld, r_b_zero;
    logic signed [V1W-1:0] r_b_x, r_b_y;
    t_angle                r_b_z;
    logic signed [15:0]    r_b_hd;

    assign b_dx = r_a_dx;
    assign b_dy = r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_x    <= b_dx[V1W-1] ? -b_dx : b_dx;
            r_b_y    <= b_dx[V1W-1] ? -b_dy : b_dy;
            r_b_z    <= b_dx[V1W-1] ? (b_dy[V1W-1] ? -PI_Q30 : PI_Q30) : '0;
            r_b_zero <= (r_a_dx == '0) && (r_a_dy == '0);
            r_b_hd   <= r_a_hd;
        end
    end

    logic                  v1_vld;
    logic signed [V1W-1:0] v1_x;
    t_angle                v1_z;
    logic [16:0]           v1_sb;

    pps_vector #(
        .W      (V1W),
        .STAGES (CORDIC_STAGES),
        .SB_W   (17)
    ) u_vec_bearing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_x     (r_b_x),
        .i_y     (r_b_y),
        .i_z     (r_b_z),
        .i_sb    ({r_b_zero, r_b_hd}),
        .o_valid (v1_vld),
        .o_x     (v1_x),
        .o_z     (v1_z),
        .o_sb    (v1_sb)
    );

    // Stage C: bearing relative to yaw, wrapped once.
    logic signed [15:0] c_hd16;
    t_angle             c_hd, c_goal;
    logic               r_c_vld;
    t_angle             r_c_bearing;
    logic [RW-1:0]      r_c_range;

    assign c_hd16 = v1_sb[15:0];
    assign c_hd   = c_hd16;
    assign c_goal = v1_sb[16] ? '0 : v1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= v1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_bearing <= wrap_once(c_goal - (c_hd <<< SH));
            r_c_range   <= v1_sb[16] ? '0 : v1_x[RW-1:0];
        end
    end

    // Stage D: bring the angle into [-pi/2, pi/2] for the sine.
    logic               r_d_vld, r_d_neg;
    t_angle             r_d_z;
    logic [RW-1:0]      r_d_range;
    logic signed [15:0] r_d_berr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_c_bearing > HALF_PI_Q30) begin
                r_d_z   <= r_c_bearing - PI_Q30;
                r_d_neg <= 1'b1;
            end else if (r_c_bearing < -HALF_PI_Q30) begin
                r_d_z   <= r_c_bearing + PI_Q30;
                r_d_neg <= 1'b1;
            end else begin
                r_d_z   <= r_c_bearing;
                r_d_neg <= 1'b0;
            end
            r_d_range <= r_c_range;
            r_d_berr  <= to_out(r_c_bearing);
        end
    end

    logic                 rot_vld;
    logic signed [RW-1:0] rot_y;
    logic [RW+16:0]       rot_sb;

    pps_rotate #(
        .W      (RW),
        .STAGES (CORDIC_STAGES),
        .SB_W   (RW + 17)
    ) u_rot_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_z     (r_d_z),
        .i_sb    ({r_d_neg, r_d_range, r_d_berr}),
        .o_valid (rot_vld),
        .o_y     (rot_y),
        .o_sb    (rot_sb)
    );

    // Stage E: undo the half-turn fold.
    logic                 r_e_vld;
    logic signed [RW-1:0] r_e_s;
    logic [RW-1:0]        r_e_range;
    logic signed [15:0]   r_e_berr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= rot_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_s     <= rot_sb[RW+16] ? -rot_y : rot_y;
            r_e_range <= rot_sb[RW+15:16];
            r_e_berr  <= rot_sb[15:0];
        end
    end

    // Stage F: gain times sine.
    logic                    r_f_vld;
    logic signed [RW+16:0]   r_f_prod;
    logic [RW-1:0]           r_f_range;
    logic signed [15:0]      r_f_berr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_prod  <= r_e_s * $signed({1'b0, r_steer_gain});
            r_f_range <= r_e_range;
            r_f_berr  <= r_e_berr;
        end
    end

    // Stage G: operands of the steering atan2; the range is scaled to match.
    logic signed [RW:0]    g_num;
    logic signed [V2W-1:0] g_y;
    logic                  r_g_vld, r_g_zero;
    logic signed [V2W-1:0] r_g_x, r_g_y;
    logic signed [15:0]    r_g_berr;

    assign g_num = r_f_prod[RW+16:16];
    assign g_y   = g_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_x    <= {{(V2W - RW - 10){1'b0}}, r_f_range, 10'b0};
            r_g_y    <= g_y;
            r_g_zero <= (g_num == '0) && (r_f_range == '0);
            r_g_berr <= r_f_berr;
        end
    end

    logic                  v2_vld;
    logic signed [V2W-1:0] v2_x;
    t_angle                v2_z;
    logic [16:0]           v2_sb;

    pps_vector #(
        .W      (V2W),
        .STAGES (CORDIC_STAGES),
        .SB_W   (17)
    ) u_vec_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_vld),
        .i_x     (r_g_x),
        .i_y     (r_g_y),
        .i_z     ('0),
        .i_sb    ({r_g_zero, r_g_berr}),
        .o_valid (v2_vld),
        .o_x     (v2_x),
        .o_z     (v2_z),
        .o_sb    (v2_sb)
    );

    // Stage H: wrap the steering angle. The magnitude is not needed.
    logic               r_h_vld;
    t_angle             r_h_steer;
    logic signed [15:0] r_h_berr;
    logic               h_unused;

    assign h_unused = ^v2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_h_vld <= v2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_steer <= (v2_sb[16] || (h_unused && 1'b0)) ? '0 : wrap_once(v2_z);
            r_h_berr  <= v2_sb[15:0];
        end
    end

    // Output register with one skid entry: the pipeline keeps moving while a
    // result waits, and stops only while the skid entry holds a second one.
    logic               r_out_vld, r_skid_vld;
    logic signed [15:0] r_out_steer, r_out_berr;
    logic signed [15:0] r_skid_steer, r_skid_berr;
    logic signed [15:0] h_steer16;

    assign en        = !r_skid_vld;
    assign arrive    = en && r_h_vld;
    assign o_ready   = en;
    assign h_steer16 = to_out(r_h_steer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= arrive;
            end
        end else if (arrive) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_steer <= r_skid_steer;
                r_out_berr  <= r_skid_berr;
            end else begin
                r_out_steer <= h_steer16;
                r_out_berr  <= r_h_berr;
            end
        end else if (arrive) begin
            r_skid_steer <= h_steer16;
            r_skid_berr  <= r_h_berr;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_steer_rate    = r_out_steer;
    assign o_bearing_error = r_out_berr;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a result with the output register empty");

    // A result arriving at a stalled, full output must go to the skid entry.
    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (arrive && r_out_vld && !i_ready) |=> r_skid_vld)
        else $error("arriving result was not captured while the output stalled");

    // A full skid entry freezes the pipeline and the input.
    a_skid_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && !o_ready && $stable(r_h_vld)))
        else $error("pipeline advanced while the skid entry was full");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_skid_vld && !r_a_vld))
        else $error("result pending after reset");

endmodule
